// File: rtl/vwlp_pkg.sv
// ----------------------------------------------------------------------------
// vwlp_pkg
// Shared types, constants and helpers of the variable width label packer.
// ----------------------------------------------------------------------------
package vwlp_pkg;

  // defaults for the top level parameters
  localparam int COORDINATES_DEF       = 128;
  localparam int MAX_PAYLOAD_BYTES_DEF = 64;

  // widest legal label width; the front packs at most one full byte per label
  localparam int MAX_WIDTH = 8;

  // fixed field widths
  localparam int LABEL_W  = 8;
  localparam int WIDTH_W  = 4;
  localparam int INDEX_W  = 6;
  localparam int USED_W   = 10;
  localparam int NBYTES_W = 7;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK              = 2'd0,
    ST_LABEL_TOO_LARGE = 2'd1,
    ST_WIDTH_OVER      = 2'd2,
    ST_OVERRUN         = 2'd3
  } status_t;

  // input beat
  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [WIDTH_W-1:0] width;
  } label_item_t;

  // result beat
  typedef struct packed {
    logic [7:0]         byte_value;
    logic [INDEX_W-1:0] byte_index;
    logic [USED_W-1:0]  bit_count;
    status_t            status;
    logic               last;
  } byte_item_t;

  // one finished set, handed from front to back
  typedef struct packed {
    logic                bank;
    logic [NBYTES_W-1:0] nbytes;
    logic [USED_W-1:0]   bit_count;
    status_t             status;
    logic [7:0]          tail;
  } desc_t;

  // payload store write request
  typedef struct packed {
    logic               en;
    logic               bank;
    logic [INDEX_W-1:0] index;
    logic [7:0]         data;
  } wr_req_t;

  // payload store read request, with bank free on the final beat of a set
  typedef struct packed {
    logic               en;
    logic               free;
    logic               bank;
    logic [INDEX_W-1:0] index;
  } rd_req_t;

  // payload length in bytes for a size select, limited by the store size
  function automatic logic [NBYTES_W-1:0] bytes_for_select(input logic sel,
                                                           input int   max_bytes);
    int n;
    n = sel ? 64 : 32;
    if (n > max_bytes) begin
      n = max_bytes;
    end
    return NBYTES_W'(n);
  endfunction

endpackage

// File: rtl/vwlp_desc_fifo.sv
// ----------------------------------------------------------------------------
// vwlp_desc_fifo
// Two entry queue of finished set descriptors between front and back.
// ----------------------------------------------------------------------------
module vwlp_desc_fifo import vwlp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  valid,
  output desc_t head
);

  desc_t       entry [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_desc;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign valid = (count != 2'd0);
  assign head  = entry[rptr];

  // the front never has more than two sets outstanding
  assert property (@(posedge clk) disable iff (rst) push |-> (count != 2'd2 || pop))
    else $error("descriptor queue overflow");
  assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("descriptor queue underflow");

endmodule

// File: rtl/vwlp_store.sv
// ----------------------------------------------------------------------------
// vwlp_store
// Two bank payload memory with per byte valid bits and bank busy flags.
// ----------------------------------------------------------------------------
module vwlp_store import vwlp_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  wr_req_t    wr,
  input  rd_req_t    rd,
  input  logic       set_busy,
  input  logic       set_bank,
  output logic [1:0] bank_busy,
  output logic [7:0] rd_data,
  output logic       rd_hit
);

  localparam int STORE_BYTES = (MAX_PAYLOAD_BYTES < 64) ? MAX_PAYLOAD_BYTES : 64;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int DEPTH       = 2 * STORE_BYTES;

  logic [7:0]                   mem [DEPTH];
  logic [1:0][STORE_BYTES-1:0]  vld;
  logic [1:0]                   busy;

  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign wr_addr = wr.index[ADDR_W-1:0];
  assign rd_addr = rd.index[ADDR_W-1:0];

  // memory write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr_addr}] <= wr.data;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[{rd.bank, rd_addr}];
      rd_hit  <= vld[rd.bank][rd_addr];
    end
  end

  // byte valid bits: set on write, whole bank cleared when it is freed
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rd.free) begin
        vld[rd.bank] <= '0;
      end
      if (wr.en) begin
        vld[wr.bank][wr_addr] <= 1'b1;
      end
    end
  end

  // bank busy from set completion until its last beat is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 2'b00;
    end else begin
      if (set_busy) begin
        busy[set_bank] <= 1'b1;
      end
      if (rd.free) begin
        busy[rd.bank] <= 1'b0;
      end
    end
  end

  assign bank_busy = busy;

  assert property (@(posedge clk) disable iff (rst) wr.en |-> !busy[wr.bank])
    else $error("write into a bank that is being drained");
  assert property (@(posedge clk) disable iff (rst) rd.free |-> busy[rd.bank])
    else $error("free of a bank that holds no set");
  assert property (@(posedge clk) disable iff (rst) rd.en |-> busy[rd.bank])
    else $error("read from a bank that holds no set");

endmodule

// File: rtl/vwlp_front.sv
// ----------------------------------------------------------------------------
// vwlp_front
// Accepts labels, checks them and packs complete bytes into the store.
// ----------------------------------------------------------------------------
module vwlp_front import vwlp_pkg::*; #(
  parameter int COORDINATES       = COORDINATES_DEF,
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  label_item_t label_item,
  input  logic        size_select,
  input  logic [1:0]  bank_busy,
  output wr_req_t     wr,
  output logic        desc_push,
  output desc_t       desc
);

  localparam int                CNT_W    = (COORDINATES > 1) ? $clog2(COORDINATES) : 1;
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(COORDINATES - 1);

  // set state
  logic [CNT_W-1:0]    cnt;
  logic [USED_W-1:0]   bit_offset;
  status_t             err;
  logic [7:0]          acc;
  logic                wbank;
  logic [NBYTES_W-1:0] set_bytes;

  logic                accept;
  logic                is_last;
  logic [NBYTES_W-1:0] cur_bytes;
  logic [15:0]         combined;
  logic [USED_W:0]     sum;
  logic [USED_W:0]     limit;
  logic [8:0]          label_hi;
  status_t             err_chk;
  logic                pack;
  logic [4:0]          fill;
  logic                byte_done;
  logic [7:0]          acc_pack;

  assign full    = bank_busy[wbank];
  assign accept  = push & ~full;
  assign is_last = (cnt == CNT_LAST);

  // payload size is sampled on the first label of a set
  assign cur_bytes = (cnt == '0) ? bytes_for_select(size_select, MAX_PAYLOAD_BYTES)
                                 : set_bytes;

  // label checks, in priority order
  always_comb begin
    sum      = {1'b0, bit_offset} + (USED_W+1)'(label_item.width);
    limit    = (USED_W+1)'({cur_bytes, 3'b000});
    label_hi = {1'b0, label_item.label} >> label_item.width;
    if (err != ST_OK) begin
      err_chk = err;
    end else if (label_item.width > WIDTH_W'(MAX_WIDTH)) begin
      err_chk = ST_WIDTH_OVER;
    end else if (label_hi != 9'd0) begin
      err_chk = ST_LABEL_TOO_LARGE;
    end else if (sum > limit) begin
      err_chk = ST_OVERRUN;
    end else begin
      err_chk = ST_OK;
    end
  end

  // merge the label into the partial byte
  always_comb begin
    pack      = (err == ST_OK) && (err_chk == ST_OK);
    combined  = {8'h00, acc} | (16'(label_item.label) << bit_offset[2:0]);
    fill      = {2'b00, bit_offset[2:0]} + {1'b0, label_item.width};
    byte_done = (fill >= 5'd8);
    acc_pack  = byte_done ? combined[15:8] : combined[7:0];
  end

  // completed byte goes to the store
  always_comb begin
    wr.en    = accept & pack & byte_done;
    wr.bank  = wbank;
    wr.index = bit_offset[8:3];
    wr.data  = combined[7:0];
  end

  // finished set descriptor
  always_comb begin
    desc_push      = accept & is_last;
    desc.bank      = wbank;
    desc.nbytes    = cur_bytes;
    desc.bit_count = pack ? sum[USED_W-1:0] : bit_offset;
    desc.status    = err_chk;
    desc.tail      = pack ? acc_pack : acc;
  end

  // set state update
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      bit_offset <= '0;
      err        <= ST_OK;
      acc        <= 8'h00;
      wbank      <= 1'b0;
    end else if (accept) begin
      if (is_last) begin
        cnt        <= '0;
        bit_offset <= '0;
        err        <= ST_OK;
        acc        <= 8'h00;
        wbank      <= ~wbank;
      end else begin
        cnt <= cnt + CNT_W'(1);
        err <= err_chk;
        if (pack) begin
          bit_offset <= sum[USED_W-1:0];
          acc        <= acc_pack;
        end
      end
    end
  end

  // latched payload size, meaningful once a set is under way
  always_ff @(posedge clk) begin
    if (accept) begin
      set_bytes <= cur_bytes;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   (err != ST_OK && !(accept && is_last)) |=> (err == $past(err)))
    else $error("first error of a set was not held");
  assert property (@(posedge clk) disable iff (rst) wr.en |-> (err == ST_OK))
    else $error("byte packed after an error");

endmodule

// File: rtl/vwlp_back.sv
// ----------------------------------------------------------------------------
// vwlp_back
// Drains finished sets from the store into a small result queue.
// ----------------------------------------------------------------------------
module vwlp_back import vwlp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       desc_valid,
  input  desc_t      desc,
  output logic       desc_pop,
  output rd_req_t    rd,
  input  logic [7:0] rd_data,
  input  logic       rd_hit,
  input  logic       pop,
  output logic       empty,
  output byte_item_t byte_item
);

  localparam int OUT_DEPTH = 4;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);
  localparam int OCNT_W    = OPTR_W + 1;

  // byte sequencer
  logic [INDEX_W-1:0] idx;
  logic               room;
  logic               issue;
  logic               is_err;
  logic               beat_last;
  logic               tail_hit;

  // read stage
  logic               s1_valid;
  logic [INDEX_W-1:0] s1_index;
  logic [USED_W-1:0]  s1_used;
  status_t            s1_status;
  logic               s1_last;
  logic               s1_use_tail;
  logic [7:0]         s1_tail;
  byte_item_t         s1_item;

  // result queue
  byte_item_t         ofifo [OUT_DEPTH];
  logic [OPTR_W-1:0]  owptr;
  logic [OPTR_W-1:0]  orptr;
  logic [OCNT_W-1:0]  ocnt;
  logic               opop;

  // issue a beat while the result queue can take it and the one in flight
  always_comb begin
    room      = (ocnt + OCNT_W'(s1_valid)) < OCNT_W'(OUT_DEPTH);
    issue     = desc_valid & room;
    is_err    = (desc.status != ST_OK);
    beat_last = is_err || (({1'b0, idx} + NBYTES_W'(1)) == desc.nbytes);
    tail_hit  = (desc.bit_count[2:0] != 3'd0) && (idx == desc.bit_count[8:3]);
    desc_pop  = issue & beat_last;
    rd.en     = issue & ~is_err;
    rd.free   = issue & beat_last;
    rd.bank   = desc.bank;
    rd.index  = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (issue) begin
      idx <= beat_last ? '0 : idx + INDEX_W'(1);
    end
  end

  // read stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_index    <= is_err ? '0 : idx;
      s1_used     <= is_err ? '0 : desc.bit_count;
      s1_status   <= desc.status;
      s1_last     <= beat_last;
      s1_use_tail <= tail_hit;
      s1_tail     <= desc.tail;
    end
  end

  // byte value: partial tail byte, stored byte, or zero for error beats and unwritten bytes
  always_comb begin
    s1_item.byte_index = s1_index;
    s1_item.bit_count  = s1_used;
    s1_item.status     = s1_status;
    s1_item.last       = s1_last;
    if (s1_status != ST_OK) begin
      s1_item.byte_value = 8'h00;
    end else if (s1_use_tail) begin
      s1_item.byte_value = s1_tail;
    end else if (rd_hit) begin
      s1_item.byte_value = rd_data;
    end else begin
      s1_item.byte_value = 8'h00;
    end
  end

  // result queue
  assign opop  = pop & ~empty;
  assign empty = (ocnt == '0);

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      ofifo[owptr] <= s1_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr <= '0;
      orptr <= '0;
      ocnt  <= '0;
    end else begin
      if (s1_valid) begin
        owptr <= owptr + OPTR_W'(1);
      end
      if (opop) begin
        orptr <= orptr + OPTR_W'(1);
      end
      ocnt <= ocnt + OCNT_W'(s1_valid) - OCNT_W'(opop);
    end
  end

  assign byte_item = ofifo[orptr];

  assert property (@(posedge clk) disable iff (rst) ocnt <= OCNT_W'(OUT_DEPTH))
    else $error("result queue overflow");
  assert property (@(posedge clk) disable iff (rst) desc_pop |-> desc_valid)
    else $error("set retired with no descriptor");

endmodule

// File: rtl/variable_width_label_packer_top.sv
// ----------------------------------------------------------------------------
// variable_width_label_packer_top
// Packs sets of variable width labels LSB first into a 32 or 64 byte payload.
// ----------------------------------------------------------------------------
// Usage:
//   Labels enter on a queue style port: a beat is taken when push is high and
//   full is low. Every COORDINATES beats form one set. Results leave the same
//   way: the oldest result sits on byte_item while empty is low and is taken
//   when pop is high. A clean set gives one beat per payload byte with
//   last on the final byte; a set with an error gives a single status beat.
//   cfg_data selects 32 (0) or 64 (1) bytes; cfg_ready is always high and the
//   value is sampled on the first label of each set.
// Timing:
//   One label per cycle while full is low and one result per cycle while pop
//   is high, sustained. The first byte of a set passes the descriptor queue,
//   the registered read stage and the result queue. The payload memory has
//   two banks, so a set is packed while the one before drains; full rises
//   only when both banks hold undelivered sets, as while the receiver stalls pop.
// Reset:
//   rst is synchronous; it empties both banks and all queues and sets the
//   payload size back to 32 bytes. No clearing pass is needed.
// ----------------------------------------------------------------------------
module variable_width_label_packer_top import vwlp_pkg::*; #(
  parameter int COORDINATES       = COORDINATES_DEF,
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  label_item_t label_item,
  output logic        empty,
  input  logic        pop,
  output byte_item_t  byte_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic       size_select;
  logic [1:0] bank_busy;
  wr_req_t    wr;
  rd_req_t    rd;
  logic       desc_push;
  desc_t      desc_in;
  logic       desc_valid;
  desc_t      desc_head;
  logic       desc_pop;
  logic [7:0] rd_data;
  logic       rd_hit;

  // payload size register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_select <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      size_select <= cfg_data;
    end
  end

  // label intake and packing
  vwlp_front #(
    .COORDINATES      (COORDINATES),
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .label_item (label_item),
    .size_select(size_select),
    .bank_busy  (bank_busy),
    .wr         (wr),
    .desc_push  (desc_push),
    .desc       (desc_in)
  );

  // two bank payload memory
  vwlp_store #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd       (rd),
    .set_busy (desc_push),
    .set_bank (desc_in.bank),
    .bank_busy(bank_busy),
    .rd_data  (rd_data),
    .rd_hit   (rd_hit)
  );

  // finished set queue
  vwlp_desc_fifo u_desc_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (desc_push),
    .push_desc(desc_in),
    .pop      (desc_pop),
    .valid    (desc_valid),
    .head     (desc_head)
  );

  // byte output sequencer
  vwlp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .desc_valid(desc_valid),
    .desc      (desc_head),
    .desc_pop  (desc_pop),
    .rd        (rd),
    .rd_data   (rd_data),
    .rd_hit    (rd_hit),
    .pop       (pop),
    .empty     (empty),
    .byte_item (byte_item)
  );

endmodule

// File: tb/sv/variable_width_label_packer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_width_label_packer_checker
// Watches the label, byte and size channels of the label packer, packs each
// set of labels on its own and compares every byte beat with the packed set.
// ----------------------------------------------------------------------------
module variable_width_label_packer_checker import vwlp_pkg::*; #(
  parameter int COORDINATES       = COORDINATES_DEF,
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  label_item_t label_item,
  input  logic        empty,
  input  logic        pop,
  input  byte_item_t  byte_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  output int          failures,
  output int          pending
);

  // shadow of the size register and of the set being packed
  logic       size_sel;
  int         set_bytes;
  int         bit_pos;
  int         labels_taken;
  status_t    first_error;
  logic [7:0] packed_bytes [MAX_PAYLOAD_BYTES];
  byte_item_t exp_beats [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    if (failures < 50) begin
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    failures++;
  endtask

  task automatic clear_set();
    foreach (packed_bytes[i]) begin
      packed_bytes[i] = 8'd0;
    end
    bit_pos      = 0;
    labels_taken = 0;
    first_error  = ST_OK;
  endtask

  // append one label to the bit stream; the last label of a set emits it
  task automatic pack_label(input label_item_t item);
    int         w;
    int         lbl;
    int         spot;
    byte_item_t beat;
    w   = item.width;
    lbl = item.label;
    // size is taken from the register on the first label of each set
    if (labels_taken == 0) begin
      set_bytes = size_sel ? 64 : 32;
      if (set_bytes > MAX_PAYLOAD_BYTES) begin
        set_bytes = MAX_PAYLOAD_BYTES;
      end
    end
    // only the first error of a set counts; later labels are just counted
    if (first_error == ST_OK) begin
      if (w > MAX_WIDTH) begin
        first_error = ST_WIDTH_OVER;
      end else if (lbl >= (1 << w)) begin
        first_error = ST_LABEL_TOO_LARGE;
      end else if (bit_pos + w > set_bytes * 8) begin
        first_error = ST_OVERRUN;
      end else begin
        for (int b = 0; b < w; b++) begin
          spot = bit_pos + b;
          if (item.label[b] && spot / 8 < MAX_PAYLOAD_BYTES) begin
            packed_bytes[spot / 8][spot % 8] = 1'b1;
          end
        end
        bit_pos += w;
      end
    end
    labels_taken++;
    if (labels_taken == COORDINATES) begin
      // a failed set leaves one status beat, a clean one every payload byte
      if (first_error != ST_OK) begin
        beat        = '0;
        beat.status = first_error;
        beat.last   = 1'b1;
        exp_beats   = {exp_beats, beat};
      end else begin
        for (int i = 0; i < set_bytes; i++) begin
          beat.byte_value = packed_bytes[i];
          beat.byte_index = INDEX_W'(i);
          beat.bit_count  = USED_W'(bit_pos);
          beat.status     = ST_OK;
          beat.last       = (i == set_bytes - 1);
          exp_beats       = {exp_beats, beat};
        end
      end
      clear_set();
    end
  endtask

  // sample all channels at the rising edge
  always @(posedge clk) begin
    byte_item_t want;
    if (rst) begin
      size_sel  = 1'b0;
      set_bytes = 32;
      clear_set();
      exp_beats.delete();
    end else begin
      // compare an accepted byte beat with the oldest expected one
      if (pop && !empty) begin
        if (exp_beats.size() == 0) begin
          report_mismatch("unexpected byte beat", byte_item, 0);
        end else begin
          want = exp_beats.pop_front();
          if (byte_item.byte_value !== want.byte_value) begin
            report_mismatch("byte_value", byte_item.byte_value, want.byte_value);
          end
          if (byte_item.byte_index !== want.byte_index) begin
            report_mismatch("byte_index", byte_item.byte_index, want.byte_index);
          end
          if (byte_item.bit_count !== want.bit_count) begin
            report_mismatch("bit_count", byte_item.bit_count, want.bit_count);
          end
          if (byte_item.status !== want.status) begin
            report_mismatch("status", byte_item.status, want.status);
          end
          if (byte_item.last !== want.last) begin
            report_mismatch("last", byte_item.last, want.last);
          end
        end
      end
      if (push && !full) begin
        pack_label(label_item);
      end
      // a size write takes effect from the next edge on
      if (cfg_valid && cfg_ready) begin
        size_sel = cfg_data;
      end
    end
    pending = exp_beats.size();
  end

endmodule

// File: tb/sv/variable_width_label_packer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_width_label_packer_top_tb
// Feeds sets of labels to the label packer at both payload sizes: one set of
// edge values that fills the payload exactly, a clean 64 byte set with no
// gaps, then one bad width, bad label or overrun set with random gaps.
// ----------------------------------------------------------------------------
module variable_width_label_packer_top_tb;
  import vwlp_pkg::*;

  localparam int COORDINATES = COORDINATES_DEF;
  localparam int SETTLE      = 16;
  localparam int EDGE_COUNT  = 12;

  // label/width pairs at the field extremes and across byte boundaries
  localparam logic [LABEL_W+WIDTH_W-1:0] EDGE_ITEMS [EDGE_COUNT] = '{
    {8'd0,   4'd0}, {8'd255, 4'd8}, {8'd0,   4'd8}, {8'd1,  4'd1},
    {8'd0,   4'd1}, {8'd128, 4'd8}, {8'd127, 4'd7}, {8'd1,  4'd8},
    {8'd170, 4'd8}, {8'd85,  4'd8}, {8'd15,  4'd4}, {8'd3,  4'd2}
  };

  typedef enum int {
    SET_EDGE,
    SET_CLEAN,
    SET_BAD_WIDTH,
    SET_BAD_LABEL,
    SET_OVERRUN
  } set_kind_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  label_item_t label_item;
  logic        empty;
  logic        pop = 1'b0;
  byte_item_t  byte_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        calm;
  int          mismatch_count;
  int          pending_bytes;

  variable_width_label_packer_top dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .label_item (label_item),
    .empty      (empty),
    .pop        (pop),
    .byte_item  (byte_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  variable_width_label_packer_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .label_item (label_item),
    .empty      (empty),
    .pop        (pop),
    .byte_item  (byte_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .failures   (mismatch_count),
    .pending    (pending_bytes)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver stalls about a third of the time unless calm
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(0, 99) >= 32);
    end
  end

  // one label beat, with random gaps ahead of it
  task automatic send_label(input label_item_t item);
    while (!calm && $urandom_range(0, 99) < 32) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    label_item <= item;
    do @(posedge clk); while (full);
  endtask

  // wait until every expected byte has left, then let the pipeline settle
  task automatic wait_drained();
    do @(posedge clk); while (pending_bytes != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(input logic sel);
    cfg_valid <= 1'b1;
    cfg_data  <= sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one full set; bad width and bad label sets are clean up to a random spot, noise after it
  task automatic run_set(input set_kind_t kind, input logic sel);
    int          cap;
    int          used;
    int          spot;
    int          maxw;
    int          w;
    label_item_t item;
    cap  = sel ? 512 : 256;
    used = 0;
    spot = $urandom_range(0, COORDINATES - 1);
    maxw = (kind == SET_EDGE) ? MAX_WIDTH : $urandom_range(1, MAX_WIDTH);
    for (int n = 0; n < COORDINATES; n++) begin
      if (kind == SET_EDGE && n < EDGE_COUNT) begin
        item = EDGE_ITEMS[n];
        used += item.width;
      end else if (kind == SET_OVERRUN) begin
        // wide legal labels run past the payload sooner or later
        w          = $urandom_range(5, MAX_WIDTH);
        item.width = WIDTH_W'(w);
        item.label = LABEL_W'($urandom_range(0, (1 << w) - 1));
      end else if ((kind == SET_BAD_WIDTH || kind == SET_BAD_LABEL) && n > spot) begin
        item.label = LABEL_W'($urandom_range(0, 255));
        item.width = WIDTH_W'($urandom_range(0, 15));
      end else if (kind == SET_BAD_WIDTH && n == spot) begin
        item.label = LABEL_W'($urandom_range(0, 255));
        item.width = WIDTH_W'($urandom_range(0, 1) ? MAX_WIDTH + 1 :
                              $urandom_range(MAX_WIDTH + 1, 15));
      end else if (kind == SET_BAD_LABEL && n == spot) begin
        w          = $urandom_range(0, MAX_WIDTH - 1);
        item.width = WIDTH_W'(w);
        item.label = LABEL_W'($urandom_range(0, 1) ? (1 << w) : $urandom_range(1 << w, 255));
      end else begin
        // legal label kept inside the payload, so it fills up exactly
        w = $urandom_range(0, maxw);
        if (w > cap - used) begin
          w = cap - used;
        end
        item.width = WIDTH_W'(w);
        item.label = LABEL_W'($urandom_range(0, (1 << w) - 1));
        used += w;
      end
      send_label(item);
    end
    push <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    set_kind_t kind;
    logic      sel;
    rst        = 1'b1;
    push       = 1'b0;
    label_item = '0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    calm       = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // edge values at the 32 byte size left by reset
    run_set(SET_EDGE, 1'b0);

    // clean set at 64 bytes with no idling on either side
    wait_drained();
    write_size(1'b1);
    calm <= 1'b1;
    run_set(SET_CLEAN, 1'b1);

    // one error set of random kind and size, with idling again
    kind = set_kind_t'(int'(SET_BAD_WIDTH) + int'($urandom_range(0, 2)));
    sel  = 1'($urandom_range(0, 1));
    wait_drained();
    calm <= 1'b0;
    write_size(sel);
    run_set(kind, sel);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
